// File: hdl/rbf_pkg.sv
// Shared types and constants for the record boundary finder.
// Depends on nothing; imported by rbf_byte_cmp, record_boundary_finder and rbf_checker.
package rbf_pkg;

  // Buffer depth default and fixed field widths
  localparam int BUF_DEPTH_DEF = 4096;
  localparam int BYTE_W        = 8;
  localparam int TGT_W         = 12;
  localparam int OFF_W         = 13;
  localparam int NL_W          = 3;

  // Marker bytes
  localparam logic [BYTE_W-1:0] MARK_START = 8'h3E;
  localparam logic [BYTE_W-1:0] MARK_NL    = 8'h0A;

  // Command modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NL_OVER   = 2'd3
  } status_t;

  // Byte class from the shared compare unit
  typedef struct packed {
    logic is_mark;
    logic is_nl;
  } byte_class_t;

  // Scan sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LAST  = 4'b0010,
    S_LEFT  = 4'b0100,
    S_RIGHT = 4'b1000
  } scan_state_t;

endpackage

// File: hdl/rbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/rbf_byte_cmp.sv
// Shared byte compare unit: classifies every word read from the store.
// Depends on rbf_pkg.
module rbf_byte_cmp (
  input  logic [rbf_pkg::BYTE_W-1:0] byte_in,
  output rbf_pkg::byte_class_t       cls
);

  import rbf_pkg::*;

  // Match against the record start and newline markers
  always_comb begin
    cls.is_mark = (byte_in == MARK_START);
    cls.is_nl   = (byte_in == MARK_NL);
  end

endmodule

// File: hdl/record_boundary_finder.sv
// Record boundary finder: byte store, scan sequencer and shared compare unit.
// Depends on rbf_pkg, rbf_ram, rbf_byte_cmp.
// Load: one word per cycle while idle, busy stays low. Search: the sequencer reads the last
// byte, then for each distance scanned does one read per side, left side first, until a
// result is found; out-of-range searches answer next cycle.
// Synchronous active-low reset empties the buffer and idles the sequencer.
module record_boundary_finder #(
  parameter int BUF_DEPTH = rbf_pkg::BUF_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [rbf_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic [rbf_pkg::TGT_W-1:0]         in_target_offset,
  input  logic                              in_first_block,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [rbf_pkg::OFF_W-1:0]  out_bound_offset
);

  import rbf_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int WW = ((CW > TGT_W) ? CW : TGT_W) + 1;

  scan_state_t          state_r, state_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [WW-1:0]        size_r, size_nxt;
  logic signed [WW-1:0] lidx_r, lidx_nxt;
  logic [WW-1:0]        ridx_r, ridx_nxt;
  logic                 first_r, first_nxt;
  logic                 zero_r, zero_nxt;
  logic                 lastnl_r, lastnl_nxt;
  logic [NL_W-1:0]      nl_r, nl_nxt;
  logic                 ovalid_r, ovalid_nxt;
  status_t              ostat_r, ostat_nxt;
  logic signed [OFF_W-1:0] ooff_r, ooff_nxt;

  logic                 accept;
  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [CW-1:0]        fill_m1;
  logic [BYTE_W-1:0]    rd_data;
  byte_class_t          cls;
  logic                 has_left, has_right;
  logic [NL_W-1:0]      nl_tot;
  logic [WW-1:0]        ridx_p1;
  logic signed [WW-1:0] lidx_m1;

  assign accept  = start && (state_r == S_IDLE);
  assign wr_en   = accept && (in_mode == MODE_LOAD) && (fill_r < CW'(BUF_DEPTH));
  assign fill_m1 = fill_r - CW'(1);
  assign ridx_p1 = ridx_r + WW'(1);
  assign lidx_m1 = lidx_r - WW'(1);

  // Buffer store
  rbf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUF_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill_r[AW-1:0]),
    .wr_data(in_data_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Classify each read word
  rbf_byte_cmp u_cmp (
    .byte_in(rd_data),
    .cls    (cls)
  );

  // Issue the read for the next state
  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = fill_m1[AW-1:0];
      S_LAST:  rd_addr = lidx_r[AW-1:0];
      S_LEFT:  rd_addr = ridx_r[AW-1:0];
      S_RIGHT: rd_addr = lidx_m1[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign has_left  = !lidx_r[WW-1];
  assign has_right = (ridx_r < size_r) && !zero_r;
  assign nl_tot    = nl_r + NL_W'(has_right && cls.is_nl);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    size_nxt   = size_r;
    lidx_nxt   = lidx_r;
    ridx_nxt   = ridx_r;
    first_nxt  = first_r;
    zero_nxt   = zero_r;
    lastnl_nxt = lastnl_r;
    nl_nxt     = nl_r;
    ovalid_nxt = 1'b0;
    ostat_nxt  = ostat_r;
    ooff_nxt   = ooff_r;
    unique case (state_r)
      S_IDLE: begin
        if (wr_en) begin
          fill_nxt = fill_r + CW'(1);
        end
        if (accept && (in_mode == MODE_SEARCH)) begin
          if (WW'(in_target_offset) >= WW'(fill_r)) begin
            // Target beyond loaded bytes
            ovalid_nxt = 1'b1;
            ostat_nxt  = ST_RANGE;
            ooff_nxt   = '0;
          end else begin
            size_nxt  = WW'(fill_r);
            lidx_nxt  = WW'(in_target_offset);
            ridx_nxt  = WW'(in_target_offset);
            first_nxt = in_first_block;
            zero_nxt  = 1'b1;
            nl_nxt    = '0;
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        // Latch whether the buffer ends in a newline
        lastnl_nxt = cls.is_nl;
        state_nxt  = S_LEFT;
      end
      S_LEFT: begin
        if (has_left && cls.is_mark && ((lidx_r != '0) || !first_r)) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_FOUND;
          ooff_nxt   = OFF_W'(lidx_m1);
          state_nxt  = S_IDLE;
        end else begin
          nl_nxt    = nl_r + NL_W'(has_left && cls.is_nl);
          state_nxt = S_RIGHT;
        end
      end
      S_RIGHT: begin
        nl_nxt   = nl_tot;
        zero_nxt = 1'b0;
        lidx_nxt = lidx_m1;
        ridx_nxt = ridx_p1;
        if (has_right && cls.is_mark) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_FOUND;
          ooff_nxt   = OFF_W'($signed(ridx_r - WW'(1)));
          state_nxt  = S_IDLE;
        end else if ((nl_tot == NL_W'(2)) && (ridx_p1 >= size_r) && lastnl_r) begin
          // Right walk at buffer end after two newlines, buffer ending in a newline: take the last offset
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_FOUND;
          ooff_nxt   = OFF_W'($signed(size_r - WW'(1)));
          state_nxt  = S_IDLE;
        end else if (nl_tot > NL_W'(2)) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_NL_OVER;
          ooff_nxt   = '0;
          state_nxt  = S_IDLE;
        end else if ((lidx_r[WW-1] || (lidx_r == '0)) && (ridx_p1 >= size_r)) begin
          // Both walks exhausted
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_NOT_FOUND;
          ooff_nxt   = '0;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_LEFT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    size_r   <= size_nxt;
    lidx_r   <= lidx_nxt;
    ridx_r   <= ridx_nxt;
    first_r  <= first_nxt;
    zero_r   <= zero_nxt;
    lastnl_r <= lastnl_nxt;
    nl_r     <= nl_nxt;
    ostat_r  <= ostat_nxt;
    ooff_r   <= ooff_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ovalid_r;
  assign out_status       = ostat_r;
  assign out_bound_offset = ooff_r;

endmodule

// File: hdl/rbf_checker.sv
// Port-level checks for the record boundary finder, bound to the top level.
// Depends on rbf_pkg and record_boundary_finder.
module rbf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             in_mode,
  input logic                             out_valid,
  input logic [1:0]                       out_status,
  input logic signed [rbf_pkg::OFF_W-1:0] out_bound_offset
);

  import rbf_pkg::*;

  // Reset idles the block and drops the strobe
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or out_valid after reset");

  // A scan begins only on an accepted search word
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_mode == MODE_SEARCH)))
    else $error("busy rose without a search word");

  // A scan ends with a result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without a result");

  // A result follows a scan or a search word
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || (start && (in_mode == MODE_SEARCH))))
    else $error("result without a search");

  // Non-found results carry offset zero
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_FOUND)) |-> (out_bound_offset == '0))
    else $error("nonzero offset on a non-found result");

endmodule

bind record_boundary_finder rbf_checker u_rbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_bound_offset(out_bound_offset)
);
